>>> rtl/core/hpc_pkg.sv
package hpc_pkg;

   // field widths
   localparam int POS_W     = 24;
   localparam int ANG_W     = 20;
   localparam int SPD_W     = 23;
   localparam int GAIN_W    = 16;
   localparam int RLIM_W    = 19;
   localparam int CSR_W     = 23;
   localparam int CSR_IDX_W = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_LINEAR_GAIN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ANGULAR_GAIN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DEFAULT_SPEED = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TURN_LIMIT    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_POS_TOL       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_HEAD_TOL      = 3'd5;

   // register reset values
   localparam logic [15:0] RST_LINEAR_GAIN   = 16'd256;
   localparam logic [15:0] RST_ANGULAR_GAIN  = 16'd512;
   localparam logic [22:0] RST_DEFAULT_SPEED = 23'd229376;
   localparam logic [18:0] RST_TURN_LIMIT    = 19'd229376;
   localparam logic [22:0] RST_POS_TOL       = 23'd3277;
   localparam logic [18:0] RST_HEAD_TOL      = 19'd3277;

   // Q16 angle constants and arithmetic limits
   localparam int PI           = 205887;
   localparam int TWO_PI       = 411775;
   localparam int HALF_PI      = 102944;
   localparam int EPS_SQ       = 42;
   localparam int CORDIC_INIT  = 39797;
   localparam int CORDIC_STEPS = 16;
   localparam int SQRT_STEPS   = 25;
   localparam int DIV_STEPS    = 23;
   localparam int POS_MAX      = 8388607;
   localparam int POS_MIN      = -8388608;

   typedef struct packed {
      logic signed [23:0] goal_x;
      logic signed [23:0] goal_y;
      logic signed [19:0] goal_heading;
      logic signed [23:0] pose_x;
      logic signed [23:0] pose_y;
      logic signed [19:0] pose_heading;
      logic [22:0]        speed_cap;
   } req_type;

   typedef struct packed {
      logic signed [23:0] body_vel_x;
      logic signed [23:0] body_vel_y;
      logic signed [19:0] turn_rate;
      logic               aligned;
   } rsp_type;

   // per-beat values that ride alongside the long arithmetic chain
   typedef struct packed {
      logic               sdx;
      logic               sdy;
      logic [23:0]        adx;
      logic [23:0]        ady;
      logic [22:0]        cap;
      logic               eps;
      logic               ok;
      logic signed [19:0] rate;
   } side_type;

   // CORDIC arctangent table, Q16
   function automatic logic [15:0] atan_q16(input int step);
      logic [15:0] r;
      case (step)
         0:       r = 16'd51472;
         1:       r = 16'd30386;
         2:       r = 16'd16055;
         3:       r = 16'd8150;
         4:       r = 16'd4091;
         5:       r = 16'd2047;
         6:       r = 16'd1024;
         7:       r = 16'd512;
         8:       r = 16'd256;
         9:       r = 16'd128;
         10:      r = 16'd64;
         11:      r = 16'd32;
         12:      r = 16'd16;
         13:      r = 16'd8;
         14:      r = 16'd4;
         15:      r = 16'd2;
         default: r = 16'd0;
      endcase
      return r;
   endfunction

   // wrap into [-pi, pi]; the window is exactly 2*pi wide so one candidate fits
   function automatic logic signed [18:0] wrap_angle(input logic signed [20:0] a);
      logic signed [22:0] c;
      logic signed [18:0] r;
      r = '0;
      for (int k = -3; k <= 3; k++) begin
         c = 23'(a) + 23'(k * TWO_PI);
         if (c >= -PI && c <= PI) begin
            r = c[18:0];
         end
      end
      return r;
   endfunction

   // saturate a wide sum to the 24 bit velocity range
   function automatic logic signed [23:0] sat_pos(input logic signed [29:0] v);
      logic signed [23:0] r;
      if (v > POS_MAX) begin
         r = 24'(POS_MAX);
      end else if (v < POS_MIN) begin
         r = 24'(POS_MIN);
      end else begin
         r = v[23:0];
      end
      return r;
   endfunction

endpackage

>>> rtl/core/holonomic_pursuit_control.sv
// Throughput: one beat per cycle unless rsp_stall holds; the 25-step square root and the 23-step
// divider are fully pipelined, one result bit per stage.
// The whole pipeline holds while a response beat waits under rsp_stall.
// Reset (synchronous, active high) clears all valid bits and loads the
// register defaults; payload registers are not reset.
module holonomic_pursuit_control
   import hpc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int SIDE_LEN = 53;
   localparam int LAST     = 4 + SIDE_LEN;

   // configuration registers
   logic [15:0] lg_ff, ag_ff;
   logic [22:0] dsl_ff, pt_ff;
   logic [18:0] trl_ff, ht_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lg_ff  <= RST_LINEAR_GAIN;
         ag_ff  <= RST_ANGULAR_GAIN;
         dsl_ff <= RST_DEFAULT_SPEED;
         trl_ff <= RST_TURN_LIMIT;
         pt_ff  <= RST_POS_TOL;
         ht_ff  <= RST_HEAD_TOL;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_LINEAR_GAIN:   lg_ff  <= csr_wdata[15:0];
            REG_ANGULAR_GAIN:  ag_ff  <= csr_wdata[15:0];
            REG_DEFAULT_SPEED: dsl_ff <= csr_wdata[22:0];
            REG_TURN_LIMIT:    trl_ff <= csr_wdata[18:0];
            REG_POS_TOL:       pt_ff  <= csr_wdata[22:0];
            REG_HEAD_TOL:      ht_ff  <= csr_wdata[18:0];
            default: ;
         endcase
      end
   end

   // pipeline control: everything moves together
   logic            adv;
   logic [LAST:0]   vld_ff;

   assign adv       = !vld_ff[LAST] || !rsp_stall;
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[LAST];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAST-1:0], req_valid};
      end
   end

   // stage 0: input beat
   req_type in_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         in_ff <= req_data;
      end
   end

   // stage 1: position and heading differences, cap select
   logic signed [24:0] dx_c, dy_c;
   logic signed [20:0] er_c;
   side_type           s1_c;
   side_type           s1_ff, s2_ff, s3_ff;
   logic signed [20:0] er1_ff;
   logic signed [19:0] ph1_ff;

   always_comb begin
      dx_c = {in_ff.goal_x[23], in_ff.goal_x} - {in_ff.pose_x[23], in_ff.pose_x};
      dy_c = {in_ff.goal_y[23], in_ff.goal_y} - {in_ff.pose_y[23], in_ff.pose_y};
      er_c = {in_ff.goal_heading[19], in_ff.goal_heading}
             - {in_ff.pose_heading[19], in_ff.pose_heading};
      s1_c      = '0;
      s1_c.sdx  = dx_c[24];
      s1_c.sdy  = dy_c[24];
      s1_c.adx  = dx_c[24] ? 24'(-dx_c) : dx_c[23:0];
      s1_c.ady  = dy_c[24] ? 24'(-dy_c) : dy_c[23:0];
      s1_c.cap  = (in_ff.speed_cap == '0) ? dsl_ff : in_ff.speed_cap;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff  <= s1_c;
         er1_ff <= er_c;
         ph1_ff <= in_ff.pose_heading;
      end
   end

   // stage 2: squares, heading error wrap, heading fold for CORDIC
   logic [47:0]        sqx2_ff, sqy2_ff;
   logic signed [18:0] err2_ff;
   logic signed [20:0] z2_ff;
   logic               fl2_ff;
   logic signed [18:0] phw_c;
   logic signed [20:0] zz_c, z_c;
   logic               fl_c;

   always_comb begin
      phw_c = wrap_angle({ph1_ff[19], ph1_ff});
      zz_c  = 21'(phw_c);
      fl_c  = 1'b0;
      z_c   = zz_c;
      if (zz_c > HALF_PI) begin
         z_c  = zz_c - 21'(PI);
         fl_c = 1'b1;
      end else if (zz_c < -HALF_PI) begin
         z_c  = zz_c + 21'(PI);
         fl_c = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sqx2_ff <= s1_ff.adx * s1_ff.adx;
         sqy2_ff <= s1_ff.ady * s1_ff.ady;
         err2_ff <= wrap_angle(er1_ff);
         z2_ff   <= z_c;
         fl2_ff  <= fl_c;
         s2_ff   <= s1_ff;
      end
   end

   // stage 3: squared distance, tolerance square, turn-rate product
   logic [48:0]        sq3_ff;
   logic [45:0]        ptsq3_ff;
   logic signed [35:0] rp3_ff;
   logic               aok3_ff;
   logic signed [20:0] z3_ff;
   logic               fl3_ff;
   logic [18:0]        aerr_c;

   assign aerr_c = err2_ff[18] ? 19'(-err2_ff) : err2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         sq3_ff   <= 49'(sqx2_ff) + 49'(sqy2_ff);
         ptsq3_ff <= pt_ff * pt_ff;
         rp3_ff   <= $signed({1'b0, ag_ff}) * err2_ff;
         aok3_ff  <= aerr_c <= ht_ff;
         z3_ff    <= z2_ff;
         fl3_ff   <= fl2_ff;
         s3_ff    <= s2_ff;
      end
   end

   // side 0: epsilon test, aligned flag, turn-rate clamp
   side_type           side_ff [0:SIDE_LEN-1];
   side_type           sd0_c;
   logic signed [35:0] rsh_c, lim_c, rcl_c;

   always_comb begin
      rsh_c = rp3_ff >>> 8;
      lim_c = $signed({17'b0, trl_ff});
      if (rsh_c > lim_c) begin
         rcl_c = lim_c;
      end else if (rsh_c < -lim_c) begin
         rcl_c = -lim_c;
      end else begin
         rcl_c = rsh_c;
      end
      sd0_c      = s3_ff;
      sd0_c.eps  = sq3_ff > 49'(EPS_SQ);
      sd0_c.ok   = (sq3_ff <= 49'(ptsq3_ff)) && aok3_ff;
      sd0_c.rate = rcl_c[19:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= sd0_c;
      end
   end

   genvar k;
   generate
      for (k = 1; k < SIDE_LEN; k++) begin : g_side
         always_ff @(posedge clock) begin
            if (adv) begin
               side_ff[k] <= side_ff[k-1];
            end
         end
      end
   endgenerate

   // integer square root, one result bit per stage
   logic [48:0] sn_ff [0:SQRT_STEPS-1];
   logic [50:0] sr_ff [0:SQRT_STEPS-1];

   generate
      for (k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
         localparam logic [50:0] BIT = 51'(1) << (48 - 2 * k);
         logic [48:0] n_i;
         logic [50:0] r_i, t_c;
         if (k == 0) begin : g_first
            assign n_i = sq3_ff;
            assign r_i = '0;
         end else begin : g_next
            assign n_i = sn_ff[k-1];
            assign r_i = sr_ff[k-1];
         end
         assign t_c = r_i + BIT;
         always_ff @(posedge clock) begin
            if (adv) begin
               if ({2'b0, n_i} >= t_c) begin
                  sn_ff[k] <= n_i - t_c[48:0];
                  sr_ff[k] <= (r_i >> 1) + BIT;
               end else begin
                  sn_ff[k] <= n_i;
                  sr_ff[k] <= r_i >> 1;
               end
            end
         end
      end
   endgenerate

   // CORDIC rotation of the folded heading, alongside the square root
   logic signed [20:0] cx_ff [0:CORDIC_STEPS-1];
   logic signed [20:0] cy_ff [0:CORDIC_STEPS-1];
   logic signed [20:0] cz_ff [0:CORDIC_STEPS-1];
   logic               fl_ff [0:CORDIC_STEPS-1];

   generate
      for (k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
         localparam logic signed [20:0] ANG = 21'(atan_q16(k));
         logic signed [20:0] x_i, y_i, z_i;
         logic               f_i;
         if (k == 0) begin : g_first
            assign x_i = 21'(CORDIC_INIT);
            assign y_i = '0;
            assign z_i = z3_ff;
            assign f_i = fl3_ff;
         end else begin : g_next
            assign x_i = cx_ff[k-1];
            assign y_i = cy_ff[k-1];
            assign z_i = cz_ff[k-1];
            assign f_i = fl_ff[k-1];
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               fl_ff[k] <= f_i;
               if (z_i >= 0) begin
                  cx_ff[k] <= x_i - (y_i >>> k);
                  cy_ff[k] <= y_i + (x_i >>> k);
                  cz_ff[k] <= z_i - ANG;
               end else begin
                  cx_ff[k] <= x_i + (y_i >>> k);
                  cy_ff[k] <= y_i - (x_i >>> k);
                  cz_ff[k] <= z_i + ANG;
               end
            end
         end
      end
   endgenerate

   // cosine and sine after unfolding, carried to the rotation stage
   logic signed [20:0] tc_ff [16:51];
   logic signed [20:0] ts_ff [16:51];

   always_ff @(posedge clock) begin
      if (adv) begin
         tc_ff[16] <= fl_ff[CORDIC_STEPS-1] ? -cx_ff[CORDIC_STEPS-1] : cx_ff[CORDIC_STEPS-1];
         ts_ff[16] <= fl_ff[CORDIC_STEPS-1] ? -cy_ff[CORDIC_STEPS-1] : cy_ff[CORDIC_STEPS-1];
      end
   end

   generate
      for (k = 17; k <= 51; k++) begin : g_trig
         always_ff @(posedge clock) begin
            if (adv) begin
               tc_ff[k] <= tc_ff[k-1];
               ts_ff[k] <= ts_ff[k-1];
            end
         end
      end
   endgenerate

   // speed: gain times distance, then cap
   logic [24:0] dd_ff [25:50];
   logic [40:0] lin_ff;
   logic [22:0] spd_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         dd_ff[25] <= sr_ff[SQRT_STEPS-1][24:0];
         lin_ff    <= lg_ff * sr_ff[SQRT_STEPS-1][24:0];
         dd_ff[26] <= dd_ff[25];
         spd_ff    <= ((lin_ff >> 8) > 41'(side_ff[25].cap)) ? side_ff[25].cap
                                                            : lin_ff[30:8];
         dd_ff[27] <= dd_ff[26];
      end
   end

   // dividends for the two velocity components
   logic [46:0] rx_ff [27:50];
   logic [46:0] ry_ff [27:50];
   logic [22:0] qx_ff [27:50];
   logic [22:0] qy_ff [27:50];

   always_ff @(posedge clock) begin
      if (adv) begin
         rx_ff[27] <= spd_ff * side_ff[26].adx;
         ry_ff[27] <= spd_ff * side_ff[26].ady;
         qx_ff[27] <= '0;
         qy_ff[27] <= '0;
      end
   end

   // restoring division by distance, one quotient bit per stage
   generate
      for (k = 28; k <= 50; k++) begin : g_div
         localparam int B = 50 - k;
         logic [47:0] trial_c;
         assign trial_c = 48'(dd_ff[k-1]) << B;
         always_ff @(posedge clock) begin
            if (adv) begin
               dd_ff[k] <= dd_ff[k-1];
               if ({1'b0, rx_ff[k-1]} >= trial_c) begin
                  rx_ff[k] <= rx_ff[k-1] - trial_c[46:0];
                  qx_ff[k] <= qx_ff[k-1] | (23'(1) << B);
               end else begin
                  rx_ff[k] <= rx_ff[k-1];
                  qx_ff[k] <= qx_ff[k-1];
               end
               if ({1'b0, ry_ff[k-1]} >= trial_c) begin
                  ry_ff[k] <= ry_ff[k-1] - trial_c[46:0];
                  qy_ff[k] <= qy_ff[k-1] | (23'(1) << B);
               end else begin
                  ry_ff[k] <= ry_ff[k-1];
                  qy_ff[k] <= qy_ff[k-1];
               end
            end
         end
      end
   endgenerate

   // signed world velocity
   logic signed [23:0] vx_ff, vy_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         vx_ff <= side_ff[50].sdx ? -$signed({1'b0, qx_ff[50]}) : $signed({1'b0, qx_ff[50]});
         vy_ff <= side_ff[50].sdy ? -$signed({1'b0, qy_ff[50]}) : $signed({1'b0, qy_ff[50]});
      end
   end

   // rotation products
   logic signed [44:0] pcx_ff, psy_ff, pcy_ff, psx_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         pcx_ff <= tc_ff[51] * vx_ff;
         psy_ff <= ts_ff[51] * vy_ff;
         pcy_ff <= tc_ff[51] * vy_ff;
         psx_ff <= ts_ff[51] * vx_ff;
      end
   end

   // sum, scale, saturate and register the response beat
   logic signed [45:0] bx_c, by_c;
   logic signed [45:0] bxs_c, bys_c;
   rsp_type            out_c;
   rsp_type            rsp_ff;

   always_comb begin
      bx_c  = 46'(pcx_ff) + 46'(psy_ff);
      by_c  = 46'(pcy_ff) - 46'(psx_ff);
      bxs_c = bx_c >>> 16;
      bys_c = by_c >>> 16;
      out_c.body_vel_x = side_ff[SIDE_LEN-1].eps ? sat_pos(bxs_c[29:0]) : '0;
      out_c.body_vel_y = side_ff[SIDE_LEN-1].eps ? sat_pos(bys_c[29:0]) : '0;
      out_c.turn_rate  = side_ff[SIDE_LEN-1].rate;
      out_c.aligned    = side_ff[SIDE_LEN-1].ok;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= out_c;
      end
   end

   assign rsp_data = rsp_ff;

endmodule
